@@ src/lfc_pkg.sv @@
package lfc_pkg;

    localparam int NUM_RULES     = 2;
    localparam int RULE_REGS     = 2;
    localparam int RULE_LIMIT    = (NUM_RULES < RULE_REGS) ? NUM_RULES : RULE_REGS;

    localparam int RULE_W        = 56;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [15:0] EAPOL_TYPE    = 16'h888E;
    localparam logic [15:0] IPV4_TYPE     = 16'h0800;
    localparam logic [7:0]  UDP_PROTO     = 8'd17;
    localparam logic [15:0] DHCP_SERVER   = 16'd67;
    localparam logic [15:0] DHCP_CLIENT   = 16'd68;
    localparam logic [7:0]  ETH_HDR_LEN   = 8'd14;
    localparam logic [7:0]  MIN_UDP_FRAME = 8'd42;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [7:0]  UDP_HDR_LEN   = 8'd8;
    localparam logic [7:0]  POS_TYPE_HI   = 8'd12;
    localparam logic [7:0]  POS_TYPE_LO   = 8'd13;
    localparam logic [7:0]  POS_IHL       = 8'd14;
    localparam logic [7:0]  POS_PROTO     = 8'd23;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BRIDGE_MODE = 2'd0,
        CFG_RULE_COUNT  = 2'd1,
        CFG_RULE_ZERO   = 2'd2,
        CFG_RULE_ONE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_LOCAL  = 2'd0,
        MODE_BRIDGE = 2'd1,
        MODE_TEST   = 2'd2,
        MODE_SPARE  = 2'd3
    } bridge_mode_t;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  protocol;
        logic [15:0] port_low;
        logic [15:0] port_high;
    } rule_t;

    localparam rule_t RULE_ZERO_RESET = '{EAPOL_TYPE, 8'd0, 16'd0, 16'd0};
    localparam rule_t RULE_ONE_RESET  = '{IPV4_TYPE, UDP_PROTO, DHCP_SERVER, DHCP_CLIENT};

    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  length;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } match_req_t;

    typedef struct packed {
        bridge_mode_t mode;
        logic [1:0]   rule_count;
        rule_t        rule_zero;
        rule_t        rule_one;
    } cfg_t;

    function automatic logic [7:0] udp_offset(input logic [3:0] header_words);
        return ETH_HDR_LEN + {2'b00, header_words, 2'b00};
    endfunction

endpackage

@@ src/lfc_cfg_regs.sv @@
module lfc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::RULE_W-1:0]       cfg_data,
    output lfc_pkg::cfg_t                    cfg
);
    import lfc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BRIDGE_MODE: cfg_next.mode       = bridge_mode_t'(cfg_data[1:0]);
                CFG_RULE_COUNT:  cfg_next.rule_count = cfg_data[1:0];
                CFG_RULE_ZERO:   cfg_next.rule_zero  = rule_t'(cfg_data);
                CFG_RULE_ONE:    cfg_next.rule_one   = rule_t'(cfg_data);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= MODE_LOCAL;
            cfg_reg.rule_count <= 2'd2;
            cfg_reg.rule_zero  <= RULE_ZERO_RESET;
            cfg_reg.rule_one   <= RULE_ONE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/lfc_parser.sv @@
module lfc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_frame_byte,
    input  logic                s_last_byte,
    input  logic                out_free,
    output lfc_pkg::match_req_t req
);
    import lfc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;

    logic [7:0]  count_reg;
    logic [15:0] ether_reg;
    logic [3:0]  hw_reg;
    logic [7:0]  proto_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;

    frame_t      frame_next;
    logic [7:0]  udp_off;

    assign advance = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready = !in_valid_reg || advance;
    assign udp_off = udp_offset(hw_reg);

    always_comb begin
        frame_next.ether_type   = ether_reg;
        frame_next.header_words = hw_reg;
        frame_next.ip_protocol  = proto_reg;
        frame_next.source_port  = sport_reg;
        frame_next.dest_port    = dport_reg;
        frame_next.length       = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
        unique case (count_reg)
            POS_TYPE_HI: begin
                frame_next.ether_type[15:8] = in_byte_reg;
            end
            POS_TYPE_LO: begin
                frame_next.ether_type[7:0] = in_byte_reg;
            end
            POS_IHL: begin
                frame_next.header_words = in_byte_reg[3:0];
            end
            POS_PROTO: begin
                frame_next.ip_protocol = in_byte_reg;
            end
            default: ;
        endcase
        if (count_reg > POS_IHL && hw_reg >= IHL_MIN) begin
            unique case (count_reg)
                udp_off: begin
                    frame_next.source_port[15:8] = in_byte_reg;
                end
                udp_off + 8'd1: begin
                    frame_next.source_port[7:0] = in_byte_reg;
                end
                udp_off + 8'd2: begin
                    frame_next.dest_port[15:8] = in_byte_reg;
                end
                udp_off + 8'd3: begin
                    frame_next.dest_port[7:0] = in_byte_reg;
                end
                default: ;
            endcase
        end
    end

    assign req.valid = advance && in_last_reg;
    assign req.frame = frame_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_frame_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ether_reg <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                count_reg <= '0;
                ether_reg <= '0;
                hw_reg    <= '0;
                proto_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
            end else begin
                count_reg <= frame_next.length;
                ether_reg <= frame_next.ether_type;
                hw_reg    <= frame_next.header_words;
                proto_reg <= frame_next.ip_protocol;
                sport_reg <= frame_next.source_port;
                dport_reg <= frame_next.dest_port;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> count_reg == '0 && ether_reg == '0)
        else $error("frame state not cleared after last byte");
    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == COUNT_MAX |=> count_reg == COUNT_MAX || count_reg == '0)
        else $error("byte counter wrapped");
`endif

endmodule

@@ src/lfc_route.sv @@
module lfc_route (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfc_pkg::cfg_t       cfg,
    input  lfc_pkg::match_req_t req,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_send_to_host,
    output logic                m_send_to_local,
    output logic                m_rule_hit
);
    import lfc_pkg::*;

    logic       m_valid_reg;
    logic       host_reg;
    logic       local_reg;
    logic       hit_reg;
    logic       host_next;
    logic       local_next;
    logic       hit_next;
    logic [1:0] active;
    rule_t      rules [RULE_REGS];

    function automatic logic rule_matches(input rule_t r, input frame_t f);
        logic ports_ok;
        logic [7:0] udp_end;
        udp_end  = udp_offset(f.header_words) + UDP_HDR_LEN;
        ports_ok = (f.source_port >= r.port_low && f.source_port <= r.port_high) ||
                   (f.dest_port >= r.port_low && f.dest_port <= r.port_high);
        if (f.ether_type != r.ether_type) begin
            return 1'b0;
        end
        if (r.protocol == 8'd0) begin
            return 1'b1;
        end
        return f.length >= MIN_UDP_FRAME && f.ip_protocol == r.protocol &&
               f.header_words >= IHL_MIN && f.length >= udp_end && ports_ok;
    endfunction

    assign rules[0] = cfg.rule_zero;
    assign rules[1] = cfg.rule_one;
    assign active   = (cfg.rule_count > 2'(RULE_LIMIT)) ? 2'(RULE_LIMIT) : cfg.rule_count;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        hit_next = 1'b0;
        if (req.frame.length >= ETH_HDR_LEN) begin
            for (int i = 0; i < RULE_REGS; i++) begin
                if (2'(i) < active && rule_matches(rules[i], req.frame)) begin
                    hit_next = 1'b1;
                end
            end
        end
        unique case (cfg.mode)
            MODE_BRIDGE: begin
                host_next  = !hit_next;
                local_next = hit_next;
            end
            MODE_TEST: begin
                host_next  = !hit_next;
                local_next = 1'b1;
            end
            default: begin
                host_next  = 1'b0;
                local_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (req.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            host_reg  <= host_next;
            local_reg <= local_next;
            hit_reg   <= hit_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_send_to_host  = host_reg;
    assign m_send_to_local = local_reg;
    assign m_rule_hit      = hit_reg;

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |-> out_free)
        else $error("result overwritten before transfer");
    a_host_means_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && host_reg |-> !hit_reg)
        else $error("hit frame routed to host");
    a_some_route: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> host_reg || local_reg)
        else $error("frame routed nowhere");
`endif

endmodule

@@ src/ethernet_local_frame_classifier_unit.sv @@
// Ethernet local-frame classifier.
//
// s_ channel: one frame byte per transfer (s_frame_byte), starting at the
// destination address; s_last_byte marks the final byte. Bytes are taken at
// one per cycle, back to back, with no gap between frames, except while a
// last byte waits for the result register. m_ channel: one result per frame
// (m_send_to_host, m_send_to_local, m_rule_hit), transferred at the earliest
// once the last byte has passed the input register and the result register.
// cfg_ channel: register writes by index (bridge mode, rule count, two
// rules), always ready; write only while no frame is in flight.
// Reset clears the frame parser, empties both registers and restores the
// default mode and rules.
// When the receiver stalls, the result is held; the following frame's bytes
// keep flowing until its own last byte reaches the input register, which
// then holds until the result register is free.
module ethernet_local_frame_classifier_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_frame_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_send_to_host,
    output logic                            m_send_to_local,
    output logic                            m_rule_hit,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfc_pkg::RULE_W-1:0]      cfg_data
);
    import lfc_pkg::*;

    cfg_t       cfg;
    match_req_t req;
    logic       out_free;

    lfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_last_byte  (s_last_byte),
        .out_free     (out_free),
        .req          (req)
    );

    lfc_route u_route (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .req             (req),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_to_host  (m_send_to_host),
        .m_send_to_local (m_send_to_local),
        .m_rule_hit      (m_rule_hit)
    );

endmodule
